### rtl/core/assert_macros.svh
// Assertion helpers for the checker file swsc_checker.sv.
// Both expect a signal named clk in the scope where they are used; ASSERT_CLKD also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/swsc_pkg.sv
`default_nettype none
package swsc_pkg;

  localparam int CHUNK_BYTES_DEF = 8192;
  localparam int SEQ_BITS_DEF    = 32;

  localparam int OP_W      = 3;
  localparam int SIZE_W    = 40;
  localparam int SEQ_IN_W  = 33;
  localparam int KIND_W    = 3;
  localparam int CSEQ_W    = 32;
  localparam int CBYTES_W  = 14;
  localparam int ERR_W     = 2;

  localparam int MAX_RETRY_W = 8;
  localparam int TIMEOUT_W   = 20;
  localparam int WINDOW_W    = 8;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam int INQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_START  = 3'd0;
  localparam logic [OP_W-1:0] OP_SLOT   = 3'd1;
  localparam logic [OP_W-1:0] OP_ACK    = 3'd2;
  localparam logic [OP_W-1:0] OP_NACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;
  localparam logic [OP_W-1:0] OP_HSACK  = 3'd5;
  localparam logic [OP_W-1:0] OP_REJECT = 3'd6;
  localparam logic [OP_W-1:0] OP_PING   = 3'd7;

  localparam logic [KIND_W-1:0] EV_META      = 3'd0;
  localparam logic [KIND_W-1:0] EV_CHUNK     = 3'd1;
  localparam logic [KIND_W-1:0] EV_RESEND    = 3'd2;
  localparam logic [KIND_W-1:0] EV_FINISHED  = 3'd3;
  localparam logic [KIND_W-1:0] EV_CONNECTED = 3'd4;
  localparam logic [KIND_W-1:0] EV_PONG      = 3'd5;
  localparam logic [KIND_W-1:0] EV_ERROR     = 3'd6;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_REJECTED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RETRIES  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TIMEOUT  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_MAX_RETRY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 2'd2;

  localparam logic [MAX_RETRY_W-1:0] MAX_RETRY_RST = 8'd3;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 20'd45000;
  localparam logic [WINDOW_W-1:0]    WINDOW_RST    = 8'd64;

  typedef struct packed {
    logic start;
    logic slot;
    logic ack;
    logic nack;
    logic tick;
    logic hsack;
    logic reject;
    logic ping;
  } op_class_t;

  typedef struct packed {
    op_class_t           cls;
    logic [SIZE_W-1:0]   size;
    logic [SEQ_IN_W-1:0] seq;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CSEQ_W-1:0]   chunk_seq;
    logic [CBYTES_W-1:0] chunk_bytes;
    logic [SIZE_W-1:0]   meta_size;
    logic [ERR_W-1:0]    error_code;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [MAX_RETRY_W-1:0] max_retry;
    logic [TIMEOUT_W-1:0]   timeout;
    logic [WINDOW_W-1:0]    window;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/core/sliding_window_sender_control_top.sv
// Sender-side control for a chunked sliding-window transfer.
// Input queue: drive in_op, in_size_bytes and in_seq_value with push; an item is
// taken at a clock edge where push is high and full is low.
// Result queue: while empty is low the oldest result is on the out_ ports; it is
// taken at a clock edge where pop is high. out_last_of_run marks the final result
// of an item (a handshake ack with a start pending gives connected, then meta).
// Registers sit on the APB port at byte addresses 0 (retry limit), 4 (timeout
// ticks) and 8 (window limit); pready is always high.
// An item waits in the input queue until the execution stage takes it and writes
// its results into the result queue, whose oldest entry drives the out_ ports.
// Throughput: one item per cycle; the execution stage handles one item a cycle
// and writes all of its results at once into a four-entry result queue.
// It waits while that queue has fewer than two free entries, so sustained
// output is one result per cycle. A two-entry input queue decouples the sides.
// When the receiver stalls, the result queue fills, execution halts, the input
// queue fills and full rises; nothing is lost.
// Reset (rst_n low at a clock edge) empties both queues, restores the register
// defaults and leaves no transfer and no handshake in progress.
`default_nettype none
module sliding_window_sender_control_top import swsc_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int SEQ_BITS    = SEQ_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [SIZE_W-1:0]     in_size_bytes,
  input  wire logic [SEQ_IN_W-1:0]   in_seq_value,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [KIND_W-1:0]     out_event_kind,
  output logic      [CSEQ_W-1:0]     out_chunk_seq,
  output logic      [CBYTES_W-1:0]   out_chunk_bytes,
  output logic      [SIZE_W-1:0]     out_meta_size,
  output logic      [ERR_W-1:0]      out_error_code,
  output logic                       out_last_of_run,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t       cfg;
  logic       item_valid;
  item_t      item;
  logic       item_pop;
  logic       room;
  logic [1:0] res_cnt;
  result_t    res0, res1, head;

  swsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swsc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .in_op         (in_op),
    .in_size_bytes (in_size_bytes),
    .in_seq_value  (in_seq_value),
    .full          (full),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  swsc_back #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .SEQ_BITS    (SEQ_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .room       (room),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  swsc_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1),
    .room    (room),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign out_event_kind  = head.kind;
  assign out_chunk_seq   = head.chunk_seq;
  assign out_chunk_bytes = head.chunk_bytes;
  assign out_meta_size   = head.meta_size;
  assign out_error_code  = head.error_code;
  assign out_last_of_run = head.last;

endmodule
`default_nettype wire

### rtl/core/swsc_regs.sv
`default_nettype none
module swsc_regs import swsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MAX_RETRY: cfg_nxt.max_retry = pwdata[MAX_RETRY_W-1:0];
        REG_TIMEOUT:   cfg_nxt.timeout   = pwdata[TIMEOUT_W-1:0];
        REG_WINDOW:    cfg_nxt.window    = pwdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_RETRY: prdata = CFG_DATA_W'(cfg_r.max_retry);
      REG_TIMEOUT:   prdata = CFG_DATA_W'(cfg_r.timeout);
      REG_WINDOW:    prdata = CFG_DATA_W'(cfg_r.window);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_retry <= MAX_RETRY_RST;
      cfg_r.timeout   <= TIMEOUT_RST;
      cfg_r.window    <= WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/swsc_front.sv
`default_nettype none
module swsc_front import swsc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [SIZE_W-1:0]   in_size_bytes,
  input  wire logic [SEQ_IN_W-1:0] in_seq_value,
  output logic                     full,
  output logic                     item_valid,
  output item_t                    item,
  input  wire logic                item_pop
);

  localparam int PTR_W = $clog2(INQ_DEPTH);
  localparam int CNT_W = $clog2(INQ_DEPTH + 1);

  function automatic op_class_t classify(input logic [OP_W-1:0] op);
    op_class_t c;
    c = '0;
    case (op)
      OP_START:  c.start  = 1'b1;
      OP_SLOT:   c.slot   = 1'b1;
      OP_ACK:    c.ack    = 1'b1;
      OP_NACK:   c.nack   = 1'b1;
      OP_TICK:   c.tick   = 1'b1;
      OP_HSACK:  c.hsack  = 1'b1;
      OP_REJECT: c.reject = 1'b1;
      default:   c.ping   = 1'b1;
    endcase
    return c;
  endfunction

  item_t            slot_r [INQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en, rd_en;
  item_t            in_item;

  assign full       = (cnt_r == CNT_W'(INQ_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = slot_r[rd_ptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = item_pop && item_valid;

  always_comb begin
    in_item.cls  = classify(in_op);
    in_item.size = in_size_bytes;
    in_item.seq  = in_seq_value;
    wr_ptr_nxt   = wr_en ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt   = rd_en ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt      = cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/swsc_back.sv
`default_nettype none
module swsc_back import swsc_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int SEQ_BITS    = SEQ_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       item_valid,
  input  wire item_t      item,
  output logic            item_pop,
  input  wire logic       room,
  output logic [1:0]      res_cnt,
  output result_t         res0,
  output result_t         res1
);

  localparam int NW = SEQ_BITS + 1;
  localparam int SW = (SEQ_BITS + 2 > 34) ? SEQ_BITS + 2 : 34;

  localparam logic [SIZE_W-1:0]   CB_SIZE = SIZE_W'(CHUNK_BYTES);
  localparam logic [CBYTES_W-1:0] CB_OUT  = CBYTES_W'(CHUNK_BYTES);
  localparam logic [NW-1:0]       SEQ_CAP = {1'b1, {SEQ_BITS{1'b0}}};
  localparam logic signed [SW-1:0] S_ONE    = SW'(1);
  localparam logic signed [SW-1:0] S_MINUS1 = SW'(-1);

  logic                    handshake_r, handshake_nxt;
  logic                    sending_r, sending_nxt;
  logic                    start_pend_r, start_pend_nxt;
  logic [SIZE_W-1:0]       pend_size_r, pend_size_nxt;
  logic [SIZE_W-1:0]       bytes_left_r, bytes_left_nxt;
  logic [NW-1:0]           next_seq_r, next_seq_nxt;
  logic signed [SW-1:0]    acked_r, acked_nxt;
  logic signed [SW-1:0]    purge_r, purge_nxt;
  logic [MAX_RETRY_W-1:0]  retry_r, retry_nxt;
  logic [TIMEOUT_W-1:0]    idle_r, idle_nxt;
  logic [CBYTES_W-1:0]     last_len_r, last_len_nxt;

  logic                    go;
  logic signed [SW-1:0]    sv, next_s, top, lim, purge_slot, diff_slot;
  logic                    win_full, unrel_slot, unrel_now, all_sent;
  logic [SIZE_W-1:0]       send_len;
  logic                    nack_hit;
  logic [CBYTES_W-1:0]     resend_len;
  logic [TIMEOUT_W-1:0]    idle_inc;
  logic [MAX_RETRY_W-1:0]  retry_inc;
  logic                    do_begin;
  logic [SIZE_W-1:0]       begin_size;

  assign go       = item_valid && room;
  assign item_pop = go;

  always_comb begin
    sv         = SW'($signed(item.seq));
    next_s     = $signed({{(SW-NW){1'b0}}, next_seq_r});
    top        = next_s - S_ONE;
    lim        = (acked_r < top) ? acked_r : top;
    purge_slot = (lim > purge_r) ? lim : purge_r;
    diff_slot  = top - purge_slot;
    win_full   = diff_slot > $signed({{(SW-WINDOW_W){1'b0}}, cfg.window});
    unrel_slot = top > purge_slot;
    unrel_now  = top > purge_r;
    all_sent   = (bytes_left_r == '0) || (next_seq_r == SEQ_CAP);
    send_len   = (bytes_left_r < CB_SIZE) ? bytes_left_r : CB_SIZE;
    nack_hit   = (sv > purge_r) && (sv < next_s);
    resend_len = (sv == top) ? last_len_r : CB_OUT;
    idle_inc   = (idle_r == '1) ? idle_r : idle_r + TIMEOUT_W'(1);
    retry_inc  = (retry_r == '1) ? retry_r : retry_r + MAX_RETRY_W'(1);
  end

  always_comb begin
    handshake_nxt  = handshake_r;
    sending_nxt    = sending_r;
    start_pend_nxt = start_pend_r;
    pend_size_nxt  = pend_size_r;
    bytes_left_nxt = bytes_left_r;
    next_seq_nxt   = next_seq_r;
    acked_nxt      = acked_r;
    purge_nxt      = purge_r;
    retry_nxt      = retry_r;
    idle_nxt       = idle_r;
    last_len_nxt   = last_len_r;
    do_begin       = 1'b0;
    begin_size     = item.size;
    res0           = '0;
    res0.last      = 1'b1;
    res1           = '0;
    res_cnt        = 2'd0;

    if (go) begin
      if (item.cls.start) begin
        start_pend_nxt = 1'b1;
        pend_size_nxt  = item.size;
        if (handshake_r) begin
          do_begin       = 1'b1;
          res0.kind      = EV_META;
          res0.meta_size = item.size;
          res_cnt        = 2'd1;
        end
      end else if (item.cls.slot) begin
        if (sending_r) begin
          purge_nxt = purge_slot;
          if (!win_full) begin
            if (all_sent) begin
              if (!unrel_slot) begin
                sending_nxt = 1'b0;
                res0.kind   = EV_FINISHED;
                res_cnt     = 2'd1;
              end
            end else begin
              res0.kind        = EV_CHUNK;
              res0.chunk_seq   = CSEQ_W'(next_seq_r);
              res0.chunk_bytes = CBYTES_W'(send_len);
              res_cnt          = 2'd1;
              last_len_nxt     = CBYTES_W'(send_len);
              idle_nxt         = '0;
              next_seq_nxt     = next_seq_r + NW'(1);
              bytes_left_nxt   = bytes_left_r - send_len;
            end
          end
        end
      end else if (item.cls.ack) begin
        if (sv > acked_r) begin
          acked_nxt = sv;
          retry_nxt = '0;
        end
      end else if (item.cls.nack) begin
        if (retry_r >= cfg.max_retry) begin
          sending_nxt     = 1'b0;
          purge_nxt       = top;
          res0.kind       = EV_ERROR;
          res0.error_code = ERR_RETRIES;
          res_cnt         = 2'd1;
        end else if (nack_hit) begin
          res0.kind        = EV_RESEND;
          res0.chunk_seq   = CSEQ_W'(sv);
          res0.chunk_bytes = resend_len;
          res_cnt          = 2'd1;
          idle_nxt         = '0;
          retry_nxt        = retry_inc;
        end
      end else if (item.cls.tick) begin
        if (sending_r) begin
          idle_nxt = idle_inc;
          if (idle_inc >= cfg.timeout) begin
            idle_nxt = '0;
            if (unrel_now) begin
              sending_nxt     = 1'b0;
              purge_nxt       = top;
              res0.kind       = EV_ERROR;
              res0.error_code = ERR_TIMEOUT;
              res_cnt         = 2'd1;
            end
          end
        end
      end else if (item.cls.hsack) begin
        handshake_nxt = 1'b1;
        res0.kind     = EV_CONNECTED;
        res_cnt       = 2'd1;
        if (start_pend_r) begin
          do_begin       = 1'b1;
          begin_size     = pend_size_r;
          res0.last      = 1'b0;
          res1.kind      = EV_META;
          res1.meta_size = pend_size_r;
          res1.last      = 1'b1;
          res_cnt        = 2'd2;
        end
      end else if (item.cls.reject) begin
        sending_nxt     = 1'b0;
        purge_nxt       = top;
        res0.kind       = EV_ERROR;
        res0.error_code = ERR_REJECTED;
        res_cnt         = 2'd1;
      end else begin
        res0.kind = EV_PONG;
        res_cnt   = 2'd1;
      end

      if (do_begin) begin
        bytes_left_nxt = begin_size;
        next_seq_nxt   = '0;
        acked_nxt      = S_MINUS1;
        purge_nxt      = S_MINUS1;
        retry_nxt      = '0;
        idle_nxt       = '0;
        sending_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_size_r  <= pend_size_nxt;
    bytes_left_r <= bytes_left_nxt;
    last_len_r   <= last_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      handshake_r  <= 1'b0;
      sending_r    <= 1'b0;
      start_pend_r <= 1'b0;
      next_seq_r   <= '0;
      acked_r      <= S_MINUS1;
      purge_r      <= S_MINUS1;
      retry_r      <= '0;
      idle_r       <= '0;
    end else begin
      handshake_r  <= handshake_nxt;
      sending_r    <= sending_nxt;
      start_pend_r <= start_pend_nxt;
      next_seq_r   <= next_seq_nxt;
      acked_r      <= acked_nxt;
      purge_r      <= purge_nxt;
      retry_r      <= retry_nxt;
      idle_r       <= idle_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/swsc_outq.sv
`default_nettype none
module swsc_outq import swsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] res_cnt,
  input  wire result_t    res0,
  input  wire result_t    res1,
  output logic            room,
  output logic            empty,
  input  wire logic       pop,
  output result_t         head
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  result_t          ent_r [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr0, wr1, rd_en;

  assign empty = (cnt_r == '0);
  assign room  = (cnt_r <= CNT_W'(OUTQ_DEPTH - 2));
  assign head  = ent_r[rd_ptr_r];
  assign wr0   = (res_cnt != 2'd0);
  assign wr1   = (res_cnt == 2'd2);
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(res_cnt);
    rd_ptr_nxt = rd_en ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(res_cnt) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      ent_r[wr_ptr_r] <= res0;
    end
    if (wr1) begin
      ent_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/swsc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module swsc_checker import swsc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  push,
  input wire logic                  full,
  input wire logic [OP_W-1:0]       in_op,
  input wire logic [SIZE_W-1:0]     in_size_bytes,
  input wire logic [SEQ_IN_W-1:0]   in_seq_value,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [KIND_W-1:0]     out_event_kind,
  input wire logic [CSEQ_W-1:0]     out_chunk_seq,
  input wire logic [CBYTES_W-1:0]   out_chunk_bytes,
  input wire logic [SIZE_W-1:0]     out_meta_size,
  input wire logic [ERR_W-1:0]      out_error_code,
  input wire logic                  out_last_of_run,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [CFG_ADDR_W-1:0] paddr,
  input wire logic [CFG_DATA_W-1:0] pwdata,
  input wire logic [CFG_DATA_W-1:0] prdata,
  input wire logic                  pready
);

  // Both queues come out of reset empty.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty && !full, "queues not empty after reset")

  // A waiting result stays put until it is taken.
  `ASSERT_CLKD(a_head_hold, !empty && !pop |=> !empty && $stable(out_event_kind) && $stable(out_chunk_seq) && $stable(out_chunk_bytes) && $stable(out_meta_size) && $stable(out_error_code) && $stable(out_last_of_run), "waiting result changed")

  // An error item always carries a reason, and only an error item does.
  `ASSERT_CLKD(a_error_code, !empty |-> ((out_event_kind == EV_ERROR) == (out_error_code != ERR_NONE)), "error code does not match item kind")

  // A connected item that is not last is followed at once by the meta item.
  `ASSERT_CLKD(a_conn_meta, !empty && pop && out_event_kind == EV_CONNECTED && !out_last_of_run |=> !empty && out_event_kind == EV_META && out_last_of_run, "meta does not follow connected")

endmodule

bind sliding_window_sender_control_top swsc_checker u_checker (.*);
`default_nettype wire

### tb/sv/sender_event_checker.sv
module sender_event_checker import swsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  logic [OP_W-1:0]       in_op,
  input  logic [SIZE_W-1:0]     in_size_bytes,
  input  logic [SEQ_IN_W-1:0]   in_seq_value,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [KIND_W-1:0]     out_event_kind,
  input  logic [CSEQ_W-1:0]     out_chunk_seq,
  input  logic [CBYTES_W-1:0]   out_chunk_bytes,
  input  logic [SIZE_W-1:0]     out_meta_size,
  input  logic [ERR_W-1:0]      out_error_code,
  input  logic                  out_last_of_run,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    outstanding
);

  logic [MAX_RETRY_W-1:0] retry_lim;
  logic [TIMEOUT_W-1:0]   tick_lim;
  logic [WINDOW_W-1:0]    win_lim;

  logic                   hs_done;
  logic                   tx_active;
  logic                   start_held;
  logic [SIZE_W-1:0]      held_size;
  logic [SIZE_W-1:0]      file_size;
  logic [32:0]            n_chunks;
  logic [32:0]            seq_next;
  logic signed [33:0]     ack_top;
  logic signed [33:0]     purge_top;
  logic [7:0]             retries;
  logic [TIMEOUT_W-1:0]   tick_count;

  result_t awaited_events[$];

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  function automatic longint in_flight();
    longint top;
    top = longint'(seq_next) - 1;
    return (top > longint'(purge_top)) ? top - longint'(purge_top) : 0;
  endfunction

  function automatic logic [CBYTES_W-1:0] len_of(input logic [32:0] s);
    logic [63:0] rem;
    rem = 64'(file_size) - 64'(s) * 64'(CHUNK_BYTES_DEF);
    return (rem < 64'(CHUNK_BYTES_DEF)) ? rem[CBYTES_W-1:0] : CBYTES_W'(CHUNK_BYTES_DEF);
  endfunction

  function automatic void post(input logic [KIND_W-1:0] k, input logic [CSEQ_W-1:0] s,
                               input logic [CBYTES_W-1:0] b, input logic [SIZE_W-1:0] m,
                               input logic [ERR_W-1:0] e, input logic l);
    result_t r;
    r.kind = k;
    r.chunk_seq = s;
    r.chunk_bytes = b;
    r.meta_size = m;
    r.error_code = e;
    r.last = l;
    awaited_events.push_back(r);
  endfunction

  function automatic void begin_file(input logic [SIZE_W-1:0] sz);
    logic [63:0] cnt;
    file_size = sz;
    cnt = (64'(sz) + 64'(CHUNK_BYTES_DEF - 1)) / 64'(CHUNK_BYTES_DEF);
    if (cnt > (64'd1 << SEQ_BITS_DEF)) cnt = 64'd1 << SEQ_BITS_DEF;
    n_chunks = cnt[32:0];
    seq_next = '0;
    ack_top = -34'sd1;
    purge_top = -34'sd1;
    retries = '0;
    tick_count = '0;
    tx_active = 1'b1;
  endfunction

  function automatic void cancel_file();
    tx_active = 1'b0;
    purge_top = 34'(longint'(seq_next) - 1);
  endfunction

  function automatic void advance_sender(input logic [OP_W-1:0] op,
                                         input logic [SIZE_W-1:0] sz,
                                         input logic [SEQ_IN_W-1:0] sq);
    longint sv;
    longint top;
    longint lim;
    sv = longint'($signed(sq));
    case (op)
      OP_START: begin
        start_held = 1'b1;
        held_size = sz;
        if (hs_done) begin
          begin_file(sz);
          post(EV_META, '0, '0, file_size, ERR_NONE, 1'b1);
        end
      end
      OP_SLOT: begin
        if (tx_active) begin
          top = longint'(seq_next) - 1;
          lim = (longint'(ack_top) < top) ? longint'(ack_top) : top;
          if (lim > longint'(purge_top)) purge_top = 34'(lim);
          if (in_flight() > longint'(win_lim)) begin
          end else if (seq_next >= n_chunks) begin
            if (in_flight() == 0) begin
              tx_active = 1'b0;
              post(EV_FINISHED, '0, '0, '0, ERR_NONE, 1'b1);
            end
          end else begin
            post(EV_CHUNK, seq_next[CSEQ_W-1:0], len_of(seq_next), '0, ERR_NONE, 1'b1);
            tick_count = '0;
            seq_next = seq_next + 33'd1;
          end
        end
      end
      OP_ACK: begin
        if (sv > longint'(ack_top)) begin
          ack_top = 34'(sv);
          retries = '0;
        end
      end
      OP_NACK: begin
        if (retries >= retry_lim) begin
          cancel_file();
          post(EV_ERROR, '0, '0, '0, ERR_RETRIES, 1'b1);
        end else if (sv > longint'(purge_top) && sv < longint'(seq_next)) begin
          post(EV_RESEND, sq[CSEQ_W-1:0], len_of(sq[32:0]), '0, ERR_NONE, 1'b1);
          tick_count = '0;
          if (retries != 8'hFF) retries = retries + 8'd1;
        end
      end
      OP_TICK: begin
        if (tx_active) begin
          if (tick_count != '1) tick_count = tick_count + TIMEOUT_W'(1);
          if (tick_count >= tick_lim) begin
            tick_count = '0;
            if (in_flight() != 0) begin
              cancel_file();
              post(EV_ERROR, '0, '0, '0, ERR_TIMEOUT, 1'b1);
            end
          end
        end
      end
      OP_HSACK: begin
        hs_done = 1'b1;
        if (!start_held) begin
          post(EV_CONNECTED, '0, '0, '0, ERR_NONE, 1'b1);
        end else begin
          begin_file(held_size);
          post(EV_CONNECTED, '0, '0, '0, ERR_NONE, 1'b0);
          post(EV_META, '0, '0, file_size, ERR_NONE, 1'b1);
        end
      end
      OP_REJECT: begin
        cancel_file();
        post(EV_ERROR, '0, '0, '0, ERR_REJECTED, 1'b1);
      end
      default: post(EV_PONG, '0, '0, '0, ERR_NONE, 1'b1);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      retry_lim = MAX_RETRY_RST;
      tick_lim = TIMEOUT_RST;
      win_lim = WINDOW_RST;
      hs_done = 1'b0;
      tx_active = 1'b0;
      start_held = 1'b0;
      held_size = '0;
      file_size = '0;
      n_chunks = '0;
      seq_next = '0;
      ack_top = -34'sd1;
      purge_top = -34'sd1;
      retries = '0;
      tick_count = '0;
      awaited_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_MAX_RETRY: retry_lim = pwdata[MAX_RETRY_W-1:0];
          REG_TIMEOUT:   tick_lim = pwdata[TIMEOUT_W-1:0];
          REG_WINDOW:    win_lim = pwdata[WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) advance_sender(in_op, in_size_bytes, in_seq_value);
      if (pop && !empty) begin
        if (awaited_events.size() == 0) begin
          $error("result item kind %0d arrived with nothing expected", out_event_kind);
          fail_count++;
        end else begin
          want = awaited_events.pop_front();
          check_field("event_kind", 64'(want.kind), 64'(out_event_kind));
          check_field("chunk_seq", 64'(want.chunk_seq), 64'(out_chunk_seq));
          check_field("chunk_bytes", 64'(want.chunk_bytes), 64'(out_chunk_bytes));
          check_field("meta_size", 64'(want.meta_size), 64'(out_meta_size));
          check_field("error_code", 64'(want.error_code), 64'(out_error_code));
          check_field("last_of_run", 64'(want.last), 64'(out_last_of_run));
        end
      end
    end
    outstanding = awaited_events.size();
  end

endmodule

### tb/sv/testbench.sv
module testbench;
  import swsc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 6;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic [OP_W-1:0]       in_op = '0;
  logic [SIZE_W-1:0]     in_size_bytes = '0;
  logic [SEQ_IN_W-1:0]   in_seq_value = '0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;

  logic                  full;
  logic                  empty;
  logic [KIND_W-1:0]     out_event_kind;
  logic [CSEQ_W-1:0]     out_chunk_seq;
  logic [CBYTES_W-1:0]   out_chunk_bytes;
  logic [SIZE_W-1:0]     out_meta_size;
  logic [ERR_W-1:0]      out_error_code;
  logic                  out_last_of_run;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int burst_left = 1;
  int tx_sent = 0;
  int pop_hold = 0;
  logic [1:0] pop_mode = 2'd0;

  int unsigned phase_retry[PHASES]   = '{3, 0, 255, 2, 6, 4};
  int unsigned phase_timeout[PHASES] = '{5, 1, 1048575, 0, 12, 3};
  int unsigned phase_window[PHASES]  = '{4, 0, 255, 1, 16, 2};

  sliding_window_sender_control_top u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_op(in_op), .in_size_bytes(in_size_bytes), .in_seq_value(in_seq_value),
    .empty(empty), .pop(pop),
    .out_event_kind(out_event_kind), .out_chunk_seq(out_chunk_seq),
    .out_chunk_bytes(out_chunk_bytes), .out_meta_size(out_meta_size),
    .out_error_code(out_error_code), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sender_event_checker u_check (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_op(in_op), .in_size_bytes(in_size_bytes), .in_seq_value(in_seq_value),
    .empty(empty), .pop(pop),
    .out_event_kind(out_event_kind), .out_chunk_seq(out_chunk_seq),
    .out_chunk_bytes(out_chunk_bytes), .out_meta_size(out_meta_size),
    .out_error_code(out_error_code), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (pop_hold == 0) begin
      pop_mode <= 2'($urandom_range(3));
      pop_hold <= $urandom_range(8, 80);
    end else begin
      pop_hold <= pop_hold - 1;
    end
    case (pop_mode)
      2'd0: pop <= 1'b1;
      2'd1: pop <= 1'($urandom_range(1));
      2'd2: pop <= ($urandom_range(5) == 0);
      default: pop <= ((pop_hold % 7) < 2);
    endcase
  end

  function automatic logic [SIZE_W-1:0] noise_size();
    return SIZE_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [SEQ_IN_W-1:0] noise_seq();
    return SEQ_IN_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(7))
      0: return noise_size();
      1: return '0;
      2: return SIZE_W'(CHUNK_BYTES_DEF * $urandom_range(1, 6));
      default: return SIZE_W'($urandom_range(1, 12 * CHUNK_BYTES_DEF));
    endcase
  endfunction

  function automatic logic [SEQ_IN_W-1:0] pick_seq(input int hi);
    case ($urandom_range(9))
      0: return noise_seq();
      1: return '1;
      2: return {1'b0, 32'hFFFF_FFFF};
      default: return SEQ_IN_W'(int'($urandom_range(hi + 1)) - 1);
    endcase
  endfunction

  task automatic put_item(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] sz,
                          input logic [SEQ_IN_W-1:0] sq);
    int gap;
    in_op <= op;
    in_size_bytes <= sz;
    in_seq_value <= sq;
    push <= 1'b1;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    if (op == OP_SLOT) tx_sent++;
    if (op == OP_START) tx_sent = 0;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(4) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic configure(input int unsigned retry_lim, input int unsigned tick_lim,
                           input int unsigned win_lim);
    logic [CFG_DATA_W-1:0] vals[3];
    logic [REG_IDX_W-1:0]  regs[3];
    vals = '{CFG_DATA_W'(retry_lim), CFG_DATA_W'(tick_lim), CFG_DATA_W'(win_lim)};
    regs = '{REG_MAX_RETRY, REG_TIMEOUT, REG_WINDOW};
    for (int i = 0; i < 3; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CFG_ADDR_W'({regs[i], 2'b00});
      pwdata <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic body_item();
    int r;
    logic [SEQ_IN_W-1:0] sq;
    r = $urandom_range(99);
    if (r < 45) begin
      put_item(OP_SLOT, noise_size(), noise_seq());
    end else if (r < 62) begin
      sq = ($urandom_range(2) != 0) ? SEQ_IN_W'(tx_sent - 1 - int'($urandom_range(2)))
                                     : pick_seq(tx_sent);
      put_item(OP_ACK, noise_size(), sq);
    end else if (r < 72) begin
      sq = ($urandom_range(3) != 0) ? SEQ_IN_W'(tx_sent - 1 - int'($urandom_range(3)))
                                     : pick_seq(tx_sent);
      put_item(OP_NACK, noise_size(), sq);
    end else if (r < 86) begin
      put_item(OP_TICK, noise_size(), noise_seq());
    end else if (r < 89) begin
      put_item(OP_PING, noise_size(), noise_seq());
    end else if (r < 91) begin
      put_item(OP_HSACK, noise_size(), noise_seq());
    end else if (r < 93) begin
      put_item(OP_REJECT, noise_size(), noise_seq());
    end else if (r < 95) begin
      put_item(OP_START, pick_size(), noise_seq());
    end else begin
      put_item(OP_W'($urandom()), noise_size(), noise_seq());
    end
  endtask

  task automatic random_phase(input int n);
    int made;
    int r;
    made = 0;
    while (made < n) begin
      r = $urandom_range(9);
      if (r < 2) begin
        put_item(OP_HSACK, noise_size(), noise_seq());
        made++;
      end
      put_item(OP_START, pick_size(), noise_seq());
      made++;
      if (r == 2) begin
        put_item(OP_HSACK, noise_size(), noise_seq());
        made++;
      end
      repeat ($urandom_range(10, 60)) begin
        body_item();
        made++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    configure(1, 2, 1);

    put_item(OP_PING, '0, '0);
    put_item(OP_SLOT, '1, '1);
    put_item(OP_TICK, '0, '0);
    put_item(OP_START, SIZE_W'(20000), '0);
    put_item(OP_HSACK, '0, '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_ACK, '0, SEQ_IN_W'(0));
    put_item(OP_ACK, '0, '1);
    put_item(OP_NACK, '0, SEQ_IN_W'(1));
    put_item(OP_NACK, '0, SEQ_IN_W'(1));
    put_item(OP_START, '0, '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_START, '1, '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_TICK, '0, '0);
    put_item(OP_TICK, '0, '0);
    put_item(OP_HSACK, '1, '1);
    put_item(OP_REJECT, '0, '0);
    put_item(OP_ACK, '0, {1'b0, 32'hFFFF_FFFF});
    put_item(OP_NACK, '0, '1);
    put_item(OP_START, SIZE_W'(CHUNK_BYTES_DEF), '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_SLOT, '0, '0);
    put_item(OP_ACK, '0, SEQ_IN_W'(0));
    put_item(OP_SLOT, '0, '0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      configure(phase_retry[p], phase_timeout[p], phase_window[p]);
      random_phase(130);
      settle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
